@@ sv/bandlimited_square_table_gen_macros.svh @@
// Assertion macros shared by the band-limited square table generator.
// Plain text macros only; no other files are needed.
`ifndef BANDLIMITED_SQUARE_TABLE_GEN_MACROS_SVH
`define BANDLIMITED_SQUARE_TABLE_GEN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bsq_pkg.sv @@
// Package for the band-limited square table generator: sizes, fixed-point
// constants, the sequencer state type and the inter-module structs. No dependencies.
`default_nettype none

package bsq_pkg;

    // Table geometry and harmonic limits.
    localparam int unsigned TABLE_SIZE   = 2048;
    localparam int unsigned NUM_OCTAVES  = 8;
    localparam int unsigned MAX_HARMONIC = 2048;
    localparam int unsigned PHASE_W      = $clog2(TABLE_SIZE);
    localparam int unsigned TURN_SHIFT   = 16 - PHASE_W;

    // Configuration register.
    localparam int unsigned SR_W     = 18;
    localparam int unsigned SR_RESET = 44100;

    // floor(x / 55) for any 18-bit x is (x * 305041) >> 24.
    localparam int unsigned DIV55_MULT  = 305041;
    localparam int unsigned DIV55_SHIFT = 24;
    localparam int unsigned Q55_W       = 13;

    // Sine polynomial in Q24, argument in Q14.
    localparam int unsigned FRAC_SHIFT = 14;
    localparam int unsigned COEF_C7    = 78547;
    localparam int unsigned COEF_C5    = 1337020;
    localparam int unsigned COEF_C3    = 10837479;
    localparam int unsigned COEF_C1    = 26353589;
    localparam int unsigned QUARTER    = 16384;
    localparam int unsigned SINE_ROUND = 256;
    localparam int unsigned SINE_SHIFT = 9;
    localparam int unsigned SINE_MAX   = 32767;

    // Output scaling by 4/pi in Q16 and rounding to Q2.14.
    localparam int unsigned FOUR_OVER_PI_Q16 = 83443;
    localparam int unsigned ROUND_SHIFT      = 33;
    localparam int unsigned SAT_POS          = 32767;
    localparam int unsigned SAT_NEG_MAG      = 32768;

    // Shared multiplier operand widths.
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 19;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // Reciprocal divider: floor((65536 + floor(k/2)) / k), four quotient bits a cycle.
    localparam int unsigned RECIP_NUM   = 65536;
    localparam int unsigned RECIP_W     = 17;
    localparam int unsigned DIV_BITS    = 4;
    localparam int unsigned DIV_CYCLES  = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KM,
        S_KMX,
        S_START,
        S_M7,
        S_M5,
        S_M3,
        S_M1,
        S_MR,
        S_ACC,
        S_SC0,
        S_SC1,
        S_SC2,
        S_SC3
    } t_state;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [RECIP_W-1:0] recip;
    } t_div_sts;

endpackage

`default_nettype wire

@@ sv/bsq_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on bsq_pkg for operand widths and the request struct.
`default_nettype none

module bsq_mul (
    input  wire logic                          i_clk,
    input  wire bsq_pkg::t_mul_req             i_req,
    output logic [bsq_pkg::MUL_P_W-1:0]        o_prod
);

    logic [bsq_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= bsq_pkg::MUL_P_W'(i_req.a) * bsq_pkg::MUL_P_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ sv/bsq_div.sv @@
// Radix-16 restoring divider that forms the Q16 reciprocal of one harmonic number.
// Depends on bsq_pkg and on the assertion macro header.
`default_nettype none
`include "bandlimited_square_table_gen_macros.svh"

module bsq_div #(
    parameter int unsigned K_W = $clog2(bsq_pkg::MAX_HARMONIC + 3)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [K_W-1:0]    i_k,
    output bsq_pkg::t_div_sts      o_sts
);

    localparam int unsigned DVD_W = bsq_pkg::DIV_BITS * bsq_pkg::DIV_CYCLES;
    localparam int unsigned CNT_W = $clog2(bsq_pkg::DIV_CYCLES + 1);

    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [K_W-1:0]   step_k;
    logic [K_W-1:0]   step_rem;
    logic [DVD_W-1:0] step_dvd;
    logic [DVD_W-1:0] step_quo;

    // A start request performs the first group of quotient bits at once.
    always_comb begin
        logic [K_W:0] rem_wide;
        step_k   = i_start ? i_k : r_k;
        step_rem = i_start ? '0 : r_rem;
        step_dvd = i_start ? (DVD_W'(bsq_pkg::RECIP_NUM) + DVD_W'(i_k >> 1)) : r_dvd;
        step_quo = i_start ? '0 : r_quo;
        for (int j = 0; j < bsq_pkg::DIV_BITS; j++) begin
            rem_wide = {step_rem, step_dvd[DVD_W-1]};
            step_dvd = step_dvd << 1;
            if (rem_wide >= {1'b0, step_k}) begin
                rem_wide = rem_wide - {1'b0, step_k};
                step_quo = {step_quo[DVD_W-2:0], 1'b1};
            end else begin
                step_quo = {step_quo[DVD_W-2:0], 1'b0};
            end
            step_rem = rem_wide[K_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(1);
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(bsq_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || r_busy) begin
            r_k   <= step_k;
            r_rem <= step_rem;
            r_dvd <= step_dvd;
            r_quo <= step_quo;
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.recip = r_quo[bsq_pkg::RECIP_W-1:0];

    `BSQ_ASSERT_NEXT(a_div_start_clears_done, i_clk, i_rst_n, i_start, !r_done, "divider reports done right after a start")
    `BSQ_ASSERT_NEXT(a_div_done_holds, i_clk, i_rst_n, r_done && !i_start, r_done, "divider result dropped without a new start")

endmodule

`default_nettype wire

@@ sv/bandlimited_square_table_gen.sv @@
// Top level of the band-limited square table generator: sequencer, accumulator,
// output register and configuration register. Depends on bsq_pkg, bsq_mul, bsq_div and the macro header.
//
// Usage. A request on the input channel (i_in_valid, o_in_stall) carries an
// octave and a table position n. The block answers with one signed Q2.14 sample
// of the band-limited square wave for that octave on the output channel
// (o_out_valid, i_out_stall). A request is taken when valid is high and stall
// is low; o_in_stall is high from the cycle after a request is taken until the
// sequencer is back in idle.
// Timing. With T the number of odd harmonics kept (T = (km + 1) / 2), a request
// runs through the harmonic limit km, T harmonic passes and the 4/pi scaling;
// the next request is taken only once the sequencer is back in idle. The pace is
// set by the single shared multiplier: each harmonic needs six dependent
// products (five for the sine polynomial, one for the reciprocal weight) and
// one accumulate step, while the reciprocal divider runs alongside.
// At 44100 Hz octave 0 keeps 200 harmonics.
// Reset. The synchronous reset returns the sequencer to idle, empties the
// output register and loads the sample rate with 44100. No clearing pass.
// Stall. A finished result waits in the output register while the receiver
// stalls; a new request may be taken meanwhile, and its result is held back in
// the last step until the register is free.
// Configuration. The sample rate is written over (i_cfg_valid, o_cfg_ready); the user
// must write it only while the block is idle, which the block does not enforce. Ready is always high.
`default_nettype none
`include "bandlimited_square_table_gen_macros.svh"

module bandlimited_square_table_gen #(
    parameter int unsigned MAX_HARMONIC = bsq_pkg::MAX_HARMONIC
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_octave,
    input  wire logic [10:0]               i_sample_index,

    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [15:0]             o_sample_value,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bsq_pkg::SR_W-1:0]  i_cfg_data
);

    localparam int unsigned K_W     = $clog2(MAX_HARMONIC + 3);
    // Each term stays below 2^31; the sum of all terms bounds the magnitude.
    localparam int unsigned MAG_W   = 31 + $clog2((MAX_HARMONIC + 1) / 2 + 1);
    localparam int unsigned ACC_W   = MAG_W + 1;
    localparam int unsigned P_W     = MAG_W + 18;
    localparam int unsigned PLO_W   = 43;
    localparam int unsigned PH_W    = bsq_pkg::PHASE_W;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned OCT_MAX = bsq_pkg::NUM_OCTAVES - 1;
    localparam int unsigned SPLIT   = bsq_pkg::MUL_A_W;

    bsq_pkg::t_state r_state, n_state;

    logic [bsq_pkg::SR_W-1:0] r_sample_rate;
    logic [2:0]               r_oct, n_oct;
    logic [PH_W-1:0]          r_phase, n_phase;
    logic [PH_W-1:0]          r_step, n_step;
    logic [K_W-1:0]           r_k, n_k;
    logic [K_W-1:0]           r_km, n_km;
    logic [14:0]              r_z, n_z;
    logic [14:0]              r_z2, n_z2;
    logic                     r_qneg, n_qneg;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic                     r_neg, n_neg;
    logic [PLO_W-1:0]         r_plo, n_plo;
    logic [15:0]              r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    bsq_pkg::t_mul_req              mul_req;
    logic [bsq_pkg::MUL_P_W-1:0]    prod;
    logic                           div_start;
    bsq_pkg::t_div_sts              div_sts;

    // Helper values derived from registers, the multiplier product and the sample index input.
    logic [IDX_W-1:0]        idx;
    logic [15:0]             turn;
    logic [14:0]             z;
    logic [bsq_pkg::Q55_W-1:0] q55;
    logic [bsq_pkg::Q55_W-1:0] km_raw;
    logic [K_W-1:0]          km_clamped;
    logic [30:0]             sine_round;
    logic [14:0]             sine_mag;
    logic [P_W-1:0]          scaled;
    logic [P_W-1:0]          out_mag;
    logic [16:0]             neg_mag;

    bsq_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    bsq_div #(
        .K_W (K_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_k     (r_k),
        .o_sts   (div_sts)
    );

    always_comb begin
        idx  = IDX_W'(i_sample_index) + IDX_W'(1);
        turn = 16'(r_phase) << bsq_pkg::TURN_SHIFT;
        // Quadrants one and three run the first quadrant backwards.
        z = turn[14] ? (15'(bsq_pkg::QUARTER) - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};

        q55    = bsq_pkg::Q55_W'(prod >> bsq_pkg::DIV55_SHIFT);
        km_raw = q55 >> (4'(r_oct) + 4'd1);
        km_clamped = (32'(km_raw) > MAX_HARMONIC) ? K_W'(MAX_HARMONIC) : K_W'(km_raw);

        sine_round = (31'(prod >> bsq_pkg::FRAC_SHIFT) + 31'(bsq_pkg::SINE_ROUND))
                     >> bsq_pkg::SINE_SHIFT;
        sine_mag   = (sine_round > 31'(bsq_pkg::SINE_MAX)) ? 15'(bsq_pkg::SINE_MAX)
                                                           : 15'(sine_round);

        scaled  = (P_W'(prod) << SPLIT) + P_W'(r_plo);
        out_mag = scaled >> bsq_pkg::ROUND_SHIFT;
        neg_mag = (out_mag > P_W'(bsq_pkg::SAT_NEG_MAG)) ? 17'(bsq_pkg::SAT_NEG_MAG)
                                                          : 17'(out_mag);
    end

    // Sequencer: next state, shared-unit requests and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_oct       = r_oct;
        n_phase     = r_phase;
        n_step      = r_step;
        n_k         = r_k;
        n_km        = r_km;
        n_z         = r_z;
        n_z2        = r_z2;
        n_qneg      = r_qneg;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_plo       = r_plo;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_req     = '0;
        div_start   = 1'b0;

        case (r_state)
            bsq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_oct   = ({1'b0, i_octave} > 4'(OCT_MAX)) ? 3'(OCT_MAX) : i_octave;
                    n_phase = PH_W'(idx);
                    n_step  = PH_W'(idx << 1);
                    n_state = bsq_pkg::S_KM;
                end
            end
            bsq_pkg::S_KM: begin
                mul_req.a = bsq_pkg::MUL_A_W'(r_sample_rate);
                mul_req.b = bsq_pkg::MUL_B_W'(bsq_pkg::DIV55_MULT);
                n_state   = bsq_pkg::S_KMX;
            end
            bsq_pkg::S_KMX: begin
                n_km    = km_clamped;
                n_k     = K_W'(1);
                n_acc   = '0;
                n_state = bsq_pkg::S_START;
            end
            bsq_pkg::S_START: begin
                if (r_k > r_km) begin
                    n_state = bsq_pkg::S_SC0;
                end else begin
                    div_start = 1'b1;
                    mul_req.a = bsq_pkg::MUL_A_W'(z);
                    mul_req.b = bsq_pkg::MUL_B_W'(z);
                    n_z       = z;
                    n_qneg    = turn[15];
                    n_state   = bsq_pkg::S_M7;
                end
            end
            bsq_pkg::S_M7: begin
                n_z2      = 15'(prod >> bsq_pkg::FRAC_SHIFT);
                mul_req.a = bsq_pkg::MUL_A_W'(bsq_pkg::COEF_C7);
                mul_req.b = bsq_pkg::MUL_B_W'(prod >> bsq_pkg::FRAC_SHIFT);
                n_state   = bsq_pkg::S_M5;
            end
            bsq_pkg::S_M5: begin
                mul_req.a = bsq_pkg::MUL_A_W'(bsq_pkg::COEF_C5)
                            - bsq_pkg::MUL_A_W'(prod >> bsq_pkg::FRAC_SHIFT);
                mul_req.b = bsq_pkg::MUL_B_W'(r_z2);
                n_state   = bsq_pkg::S_M3;
            end
            bsq_pkg::S_M3: begin
                mul_req.a = bsq_pkg::MUL_A_W'(bsq_pkg::COEF_C3)
                            - bsq_pkg::MUL_A_W'(prod >> bsq_pkg::FRAC_SHIFT);
                mul_req.b = bsq_pkg::MUL_B_W'(r_z2);
                n_state   = bsq_pkg::S_M1;
            end
            bsq_pkg::S_M1: begin
                mul_req.a = bsq_pkg::MUL_A_W'(bsq_pkg::COEF_C1)
                            - bsq_pkg::MUL_A_W'(prod >> bsq_pkg::FRAC_SHIFT);
                mul_req.b = bsq_pkg::MUL_B_W'(r_z);
                n_state   = bsq_pkg::S_MR;
            end
            bsq_pkg::S_MR: begin
                // The divider finished its last quotient bits during the polynomial.
                mul_req.a = bsq_pkg::MUL_A_W'(div_sts.recip);
                mul_req.b = bsq_pkg::MUL_B_W'(sine_mag);
                n_state   = bsq_pkg::S_ACC;
            end
            bsq_pkg::S_ACC: begin
                n_acc   = r_qneg ? (r_acc - ACC_W'(prod[31:0])) : (r_acc + ACC_W'(prod[31:0]));
                n_k     = r_k + K_W'(2);
                n_phase = r_phase + r_step;
                n_state = bsq_pkg::S_START;
            end
            bsq_pkg::S_SC0: begin
                n_neg   = r_acc[ACC_W-1];
                n_acc   = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
                n_state = bsq_pkg::S_SC1;
            end
            bsq_pkg::S_SC1: begin
                mul_req.a = r_acc[SPLIT-1:0];
                mul_req.b = bsq_pkg::MUL_B_W'(bsq_pkg::FOUR_OVER_PI_Q16);
                n_state   = bsq_pkg::S_SC2;
            end
            bsq_pkg::S_SC2: begin
                // Low partial product plus the rounding bias for the final shift.
                n_plo     = PLO_W'(prod) + (PLO_W'(1) << (bsq_pkg::ROUND_SHIFT - 1));
                mul_req.a = bsq_pkg::MUL_A_W'(r_acc >> SPLIT);
                mul_req.b = bsq_pkg::MUL_B_W'(bsq_pkg::FOUR_OVER_PI_Q16);
                n_state   = bsq_pkg::S_SC3;
            end
            bsq_pkg::S_SC3: begin
                // The high partial product is asked for again every cycle, so it is
                // still there when the result has to wait for the output register.
                mul_req.a = bsq_pkg::MUL_A_W'(r_acc >> SPLIT);
                mul_req.b = bsq_pkg::MUL_B_W'(bsq_pkg::FOUR_OVER_PI_Q16);
                if (!r_out_valid || !i_out_stall) begin
                    if (r_neg) begin
                        n_out = 16'(17'(0) - neg_mag);
                    end else if (out_mag > P_W'(bsq_pkg::SAT_POS)) begin
                        n_out = 16'(bsq_pkg::SAT_POS);
                    end else begin
                        n_out = 16'(out_mag);
                    end
                    n_out_valid = 1'b1;
                    n_state     = bsq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_sample_rate <= bsq_pkg::SR_W'(bsq_pkg::SR_RESET);
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sample_rate <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct   <= n_oct;
        r_phase <= n_phase;
        r_step  <= n_step;
        r_k     <= n_k;
        r_km    <= n_km;
        r_z     <= n_z;
        r_z2    <= n_z2;
        r_qneg  <= n_qneg;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_plo   <= n_plo;
        r_out   <= n_out;
    end

    assign o_in_stall     = (r_state != bsq_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out;
    assign o_cfg_ready    = 1'b1;

    `BSQ_ASSERT_IMPL(a_recip_ready, i_clk, i_rst_n, r_state == bsq_pkg::S_MR, div_sts.done, "reciprocal not ready when the weight product is issued")
    `BSQ_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n, r_state == bsq_pkg::S_SC3 && r_out_valid && i_out_stall, r_state == bsq_pkg::S_SC3 && r_out_valid, "result written over a waiting one")

endmodule

`default_nettype wire
